@@ rtl/rsa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the RPN stack ALU.
// Used by rsa_cell, rsa_div and rpn_stack_alu; depends on nothing.
package rsa_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int DEPTH_W     = 7;

	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		logic              is_bool;
		logic [DATA_W-1:0] val;
	} entry_t;

	typedef enum logic [4:0] {
		FN_PUSH  = 5'd0,
		FN_TRUE  = 5'd1,
		FN_FALSE = 5'd2,
		FN_NOT   = 5'd3,
		FN_CLEAR = 5'd4,
		FN_DROP  = 5'd5,
		FN_DUP   = 5'd6,
		FN_SWAP  = 5'd7,
		FN_ADD   = 5'd8,
		FN_SUB   = 5'd9,
		FN_MUL   = 5'd10,
		FN_DIV   = 5'd11,
		FN_MOD   = 5'd12,
		FN_LT    = 5'd13,
		FN_GT    = 5'd14,
		FN_LE    = 5'd15,
		FN_GE    = 5'd16,
		FN_EQ    = 5'd17,
		FN_PRINT = 5'd18
	} func_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_TYPE  = 3'd2,
		ST_DIV0  = 3'd3,
		ST_FULL  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP,
		OP_REPL,
		OP_POPLD,
		OP_SWAP
	} op_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_TAKE_UP,
		CM_TAKE_DN
	} cell_mode_t;

	typedef struct packed {
		logic start;
		logic sel_mod;
	} div_req_t;

	// Maps a whole-row operation onto the move of one cell.
	function automatic cell_mode_t cell_mode(op_t op, logic first, logic second);
		cell_mode_t m;
		m = CM_HOLD;
		unique case (op)
			OP_PUSH:  m = CM_TAKE_UP;
			OP_POP:   m = CM_TAKE_DN;
			OP_REPL:  m = first ? CM_TAKE_UP : CM_HOLD;
			OP_POPLD: m = first ? CM_TAKE_UP : CM_TAKE_DN;
			OP_SWAP:  m = first ? CM_TAKE_DN : (second ? CM_TAKE_UP : CM_HOLD);
			default:  m = CM_HOLD;
		endcase
		return m;
	endfunction

endpackage

@@ rtl/rsa_cell.sv @@
`timescale 1ns / 1ps
// One stack cell: holds a tagged entry and takes its upper or lower neighbor.
// Depends on rsa_pkg.
module rsa_cell (
	input  logic                clk,
	input  rsa_pkg::cell_mode_t mode,
	input  rsa_pkg::entry_t     up,
	input  rsa_pkg::entry_t     dn,
	output rsa_pkg::entry_t     q
);
	import rsa_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		case (mode)
			CM_TAKE_UP: entry_q <= up;
			CM_TAKE_DN: entry_q <= dn;
			default:    entry_q <= entry_q;
		endcase
	end

	assign q = entry_q;

endmodule

@@ rtl/rsa_div.sv @@
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rsa_pkg.
module rsa_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rsa_pkg::div_req_t         req,
	input  logic [rsa_pkg::DATA_W-1:0] dividend,
	input  logic [rsa_pkg::DATA_W-1:0] divisor,
	output logic                      done,
	output logic [rsa_pkg::DATA_W-1:0] result
);
	import rsa_pkg::*;

	localparam int STEP_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W-1:0] rem_q;
	logic              neg_quo_q;
	logic              neg_rem_q;
	logic              sel_mod_q;
	logic [DATA_W-1:0] abs_a;
	logic [DATA_W-1:0] abs_b;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   trial;
	logic [DATA_W-1:0] quo_out;
	logic [DATA_W-1:0] rem_out;

	assign abs_a   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign abs_b   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= abs_a;
			den_q     <= abs_b;
			rem_q     <= '0;
			neg_quo_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			neg_rem_q <= dividend[DATA_W-1];
			sel_mod_q <= req.sel_mod;
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign quo_out = neg_quo_q ? (~quo_q + 1'b1) : quo_q;
	assign rem_out = neg_rem_q ? (~rem_q + 1'b1) : rem_q;
	assign result  = sel_mod_q ? rem_out : quo_out;
	assign done    = done_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("divider did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start && step_q == STEP_W'(DATA_W - 1) |=> done_q)
		else $error("divider missed its last step");

endmodule

@@ rtl/rpn_stack_alu.sv @@
`timescale 1ns / 1ps
// RPN stack ALU: a row of rsa_cell entries (cell 0 is the top) shifted by a sequencer.
// Each item passes S_IDLE, S_EXEC and S_DONE for stack ops; binary ops add S_WB before S_DONE,
// failed ones popping two add S_POP; div and mod add S_DIV (32-step rsa_div) before S_WB.
// One item at a time; the next is taken while a result waits.
// Asynchronous reset empties the stack; entry contents are not reset.
// Depends on rsa_pkg, rsa_cell and rsa_div.
module rpn_stack_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [4:0]          func,
	input  logic signed [31:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [6:0]          depth,
	output logic                top_valid,
	output logic                top_is_bool,
	output logic signed [31:0]  top_value,
	output logic                printed
);
	import rsa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_WB,
		S_POP,
		S_DONE
	} state_t;

	state_t            state_q;
	state_t            state_c;
	func_t             func_q;
	logic [DATA_W-1:0] value_q;
	count_t            count_q;
	count_t            count_c;
	status_t           stat_q;
	status_t           stat_c;
	logic              print_q;
	logic              print_c;
	entry_t            res_q;
	entry_t            res_c;
	op_t               op_c;
	entry_t            din_c;
	div_req_t          div_req;
	logic              div_done;
	logic [DATA_W-1:0] div_result;
	entry_t            cell_q [STACK_DEPTH];
	entry_t            st0;
	entry_t            st1;
	logic [DATA_W-1:0] prod_c;
	logic              cnt_empty;
	logic              cnt_full;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [DEPTH_W-1:0] out_depth_q;
	logic              out_top_valid_q;
	entry_t            out_top_q;
	logic              out_printed_q;

	assign st0       = cell_q[0];
	assign st1       = cell_q[1];
	assign prod_c    = st1.val * st0.val;
	assign cnt_empty = (count_q == '0);
	assign cnt_full  = (count_q == CNT_W'(STACK_DEPTH));

	always_comb begin
		state_c         = state_q;
		count_c         = count_q;
		stat_c          = stat_q;
		print_c         = print_q;
		res_c           = res_q;
		op_c            = OP_HOLD;
		din_c           = res_q;
		div_req.start   = 1'b0;
		div_req.sel_mod = (func_q == FN_MOD);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_c = S_EXEC;
				end
			end
			S_EXEC: begin
				stat_c  = ST_OK;
				print_c = 1'b0;
				state_c = S_DONE;
				unique case (func_q) inside
					FN_PUSH, FN_TRUE, FN_FALSE: begin
						din_c.is_bool = (func_q != FN_PUSH);
						din_c.val     = (func_q == FN_PUSH) ? value_q :
							((func_q == FN_TRUE) ? DATA_W'(1) : '0);
						if (cnt_full) begin
							stat_c = ST_FULL;
						end else begin
							op_c    = OP_PUSH;
							count_c = count_q + 1'b1;
						end
					end
					FN_NOT: begin
						din_c.is_bool = 1'b1;
						din_c.val     = (st0.val == '0) ? DATA_W'(1) : '0;
						if (cnt_empty) begin
							stat_c = ST_EMPTY;
						end else if (!st0.is_bool) begin
							stat_c  = ST_TYPE;
							op_c    = OP_POP;
							count_c = count_q - 1'b1;
						end else begin
							op_c = OP_REPL;
						end
					end
					FN_CLEAR: begin
						count_c = '0;
					end
					FN_DROP: begin
						if (cnt_empty) begin
							stat_c = ST_EMPTY;
						end else begin
							op_c    = OP_POP;
							count_c = count_q - 1'b1;
						end
					end
					FN_DUP: begin
						din_c = st0;
						if (cnt_empty) begin
							stat_c = ST_EMPTY;
						end else if (cnt_full) begin
							stat_c = ST_FULL;
						end else begin
							op_c    = OP_PUSH;
							count_c = count_q + 1'b1;
						end
					end
					FN_PRINT: begin
						if (cnt_empty) begin
							stat_c = ST_EMPTY;
						end else begin
							print_c = 1'b1;
						end
					end
					FN_SWAP, [FN_ADD:FN_EQ]: begin
						if (cnt_empty) begin
							stat_c = ST_EMPTY;
						end else if (count_q == CNT_W'(1)) begin
							stat_c  = ST_EMPTY;
							op_c    = OP_POP;
							count_c = '0;
						end else if (func_q == FN_SWAP) begin
							op_c = OP_SWAP;
						end else if (func_q == FN_EQ) begin
							res_c.is_bool = 1'b1;
							res_c.val     = DATA_W'(st0 == st1);
							state_c       = S_WB;
						end else if (st0.is_bool || st1.is_bool) begin
							stat_c  = ST_TYPE;
							op_c    = OP_POP;
							count_c = count_q - 1'b1;
							state_c = S_POP;
						end else if ((func_q == FN_DIV || func_q == FN_MOD) && st0.val == '0) begin
							stat_c  = ST_DIV0;
							op_c    = OP_POP;
							count_c = count_q - 1'b1;
							state_c = S_POP;
						end else if (func_q == FN_DIV || func_q == FN_MOD) begin
							div_req.start = 1'b1;
							state_c       = S_DIV;
						end else begin
							res_c.is_bool = (func_q != FN_ADD) && (func_q != FN_SUB) &&
								(func_q != FN_MUL);
							unique case (func_q) inside
								FN_ADD:  res_c.val = st1.val + st0.val;
								FN_SUB:  res_c.val = st1.val - st0.val;
								FN_MUL:  res_c.val = prod_c;
								FN_LT:   res_c.val = DATA_W'($signed(st1.val) < $signed(st0.val));
								FN_GT:   res_c.val = DATA_W'($signed(st1.val) > $signed(st0.val));
								FN_LE:   res_c.val = DATA_W'($signed(st1.val) <= $signed(st0.val));
								default: res_c.val = DATA_W'($signed(st1.val) >= $signed(st0.val));
							endcase
							state_c = S_WB;
						end
					end
					default: begin
						stat_c = ST_OK;
					end
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					res_c.is_bool = 1'b0;
					res_c.val     = div_result;
					state_c       = S_WB;
				end
			end
			S_WB: begin
				op_c    = OP_POPLD;
				count_c = count_q - 1'b1;
				state_c = S_DONE;
			end
			S_POP: begin
				op_c    = OP_POP;
				count_c = count_q - 1'b1;
				state_c = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_c = S_IDLE;
				end
			end
			default: state_c = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			stat_q      <= ST_OK;
			print_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_c;
			count_q <= count_c;
			stat_q  <= stat_c;
			print_q <= print_c;
			if (state_q == S_DONE && state_c == S_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_c;
		if (in_valid && in_ready) begin
			func_q  <= func_t'(func);
			value_q <= value;
		end
		if (state_q == S_DONE && state_c == S_IDLE) begin
			out_status_q    <= stat_q;
			out_depth_q     <= DEPTH_W'(count_q);
			out_top_valid_q <= !cnt_empty;
			out_top_q       <= cnt_empty ? '0 : st0;
			out_printed_q   <= print_q;
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		entry_t up;
		entry_t dn;
		if (i == 0) begin : g_first
			assign up = din_c;
		end else begin : g_up
			assign up = cell_q[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign dn = din_c;
		end else begin : g_dn
			assign dn = cell_q[i+1];
		end
		rsa_cell u_cell (
			.clk  (clk),
			.mode (cell_mode(op_c, i == 0, i == 1)),
			.up   (up),
			.dn   (dn),
			.q    (cell_q[i])
		);
	end

	rsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (st1.val),
		.divisor  (st0.val),
		.done     (div_done),
		.result   (div_result)
	);

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign depth       = out_depth_q;
	assign top_valid   = out_top_valid_q;
	assign top_is_bool = out_top_q.is_bool;
	assign top_value   = out_top_q.val;
	assign printed     = out_printed_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_EXEC)
		else $error("accepted transfer not executed");
	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && printed |-> status == ST_OK && top_valid)
		else $error("print reported on failed item");
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !top_valid |-> top_value == '0 && !top_is_bool && depth == '0)
		else $error("empty stack reports a top entry");

endmodule

@@ tb/rsa_token_checker.sv @@
`timescale 1ns / 1ps
// Result checker for rpn_stack_alu: tracks both channels, runs its own stack model
// and compares each result transfer field by field. Depends on rsa_pkg.
module rsa_token_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [4:0]         func,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [2:0]         status,
	input  logic [6:0]         depth,
	input  logic               top_valid,
	input  logic               top_is_bool,
	input  logic signed [31:0] top_value,
	input  logic               printed,
	output int                 errors,
	output int                 pending
);
	import rsa_pkg::*;

	localparam int IDX_W = $clog2(STACK_DEPTH);

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  depth;
		logic        top_valid;
		logic        top_is_bool;
		logic [31:0] top_value;
		logic        printed;
	} token_result_t;

	entry_t        stack_mem [STACK_DEPTH];
	int            stack_count;
	token_result_t pending_results [$];
	token_result_t want;

	function automatic bit pop_entry(output entry_t e);
		if (stack_count == 0)
			return 1'b0;
		stack_count--;
		e = stack_mem[IDX_W'(stack_count)];
		return 1'b1;
	endfunction

	function automatic bit push_entry(input logic is_bool, input logic [31:0] val);
		if (stack_count >= STACK_DEPTH)
			return 1'b0;
		stack_mem[IDX_W'(stack_count)] = '{is_bool: is_bool, val: val};
		stack_count++;
		return 1'b1;
	endfunction

	function automatic status_t apply_binary(input logic [4:0] f, input entry_t a, input entry_t b);
		longint      sa;
		longint      sb;
		longint      q;
		logic [31:0] res;
		logic        res_bool;
		if (f == FN_EQ)
			return push_entry(1'b1, {31'b0, a == b}) ? ST_OK : ST_FULL;
		if (a.is_bool || b.is_bool)
			return ST_TYPE;
		sa = longint'(signed'(a.val));
		sb = longint'(signed'(b.val));
		res = '0;
		res_bool = 1'b0;
		case (f)
			FN_ADD: res = a.val + b.val;
			FN_SUB: res = a.val - b.val;
			FN_MUL: res = a.val * b.val;
			FN_DIV, FN_MOD: begin
				if (sb == 0)
					return ST_DIV0;
				q = (f == FN_DIV) ? sa / sb : sa % sb;
				res = q[31:0];
			end
			FN_LT: begin res_bool = 1'b1; res = {31'b0, sa < sb}; end
			FN_GT: begin res_bool = 1'b1; res = {31'b0, sa > sb}; end
			FN_LE: begin res_bool = 1'b1; res = {31'b0, sa <= sb}; end
			default: begin res_bool = 1'b1; res = {31'b0, sa >= sb}; end
		endcase
		return push_entry(res_bool, res) ? ST_OK : ST_FULL;
	endfunction

	function automatic token_result_t step_stack(input logic [4:0] f, input logic [31:0] v);
		token_result_t r;
		entry_t        a;
		entry_t        b;
		status_t       st;
		r = '0;
		st = ST_OK;
		case (f)
			FN_PUSH:  st = push_entry(1'b0, v) ? ST_OK : ST_FULL;
			FN_TRUE:  st = push_entry(1'b1, 32'd1) ? ST_OK : ST_FULL;
			FN_FALSE: st = push_entry(1'b1, 32'd0) ? ST_OK : ST_FULL;
			FN_NOT: begin
				if (!pop_entry(a))
					st = ST_EMPTY;
				else if (!a.is_bool)
					st = ST_TYPE;
				else
					st = push_entry(1'b1, {31'b0, ~|a.val}) ? ST_OK : ST_FULL;
			end
			FN_CLEAR: stack_count = 0;
			FN_DROP: begin
				if (!pop_entry(a))
					st = ST_EMPTY;
			end
			FN_DUP: begin
				if (stack_count == 0)
					st = ST_EMPTY;
				else begin
					a = stack_mem[IDX_W'(stack_count - 1)];
					st = push_entry(a.is_bool, a.val) ? ST_OK : ST_FULL;
				end
			end
			FN_SWAP: begin
				if (!pop_entry(b) || !pop_entry(a))
					st = ST_EMPTY;
				else begin
					void'(push_entry(b.is_bool, b.val));
					void'(push_entry(a.is_bool, a.val));
				end
			end
			FN_PRINT: begin
				if (stack_count == 0)
					st = ST_EMPTY;
				else
					r.printed = 1'b1;
			end
			FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD,
			FN_LT, FN_GT, FN_LE, FN_GE, FN_EQ: begin
				if (!pop_entry(b) || !pop_entry(a))
					st = ST_EMPTY;
				else
					st = apply_binary(f, a, b);
			end
			default: ;
		endcase
		r.status = st;
		r.depth = 7'(stack_count);
		if (stack_count > 0) begin
			r.top_valid = 1'b1;
			r.top_is_bool = stack_mem[IDX_W'(stack_count - 1)].is_bool;
			r.top_value = stack_mem[IDX_W'(stack_count - 1)].val;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			stack_count = 0;
			pending_results.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result transfer with nothing expected, status %0d depth %0d",
						$time, status, depth);
				end else begin
					want = pending_results.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("depth", 32'(want.depth), 32'(depth));
					check_field("top_valid", 32'(want.top_valid), 32'(top_valid));
					check_field("top_is_bool", 32'(want.top_is_bool), 32'(top_is_bool));
					check_field("top_value", want.top_value, top_value);
					check_field("printed", 32'(want.printed), 32'(printed));
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(step_stack(func, value));
		end
		pending = pending_results.size();
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the rpn_stack_alu testbench: clock, reset, token stimulus, result back-pressure
// and the verdict. Depends on rsa_pkg, rpn_stack_alu and rsa_token_checker.
module tb_top;
	import rsa_pkg::*;

	localparam logic [31:0] INT_MIN    = 32'h8000_0000;
	localparam logic [31:0] INT_MAX    = 32'h7fff_ffff;
	localparam int          IDLE_LIMIT = 4000;
	localparam int          RANDOM_ITEMS = 700;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [4:0]         func = '0;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic [6:0]         depth;
	logic               top_valid;
	logic               top_is_bool;
	logic signed [31:0] top_value;
	logic               printed;

	int check_errors;
	int check_pending;
	int tokens_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	rpn_stack_alu dut (.*);

	rsa_token_checker u_check (
		.*,
		.errors (check_errors),
		.pending(check_pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("rpn_stack_alu verification failed");
			$finish;
		end
	end

	function automatic int token_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [31:0] rand_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			case ($urandom_range(0, 4))
				0: return 32'd0;
				1: return 32'd1;
				2: return 32'hffff_ffff;
				3: return INT_MIN;
				default: return INT_MAX;
			endcase
		end
		if (r < 50)
			return 32'($urandom_range(0, 40)) - 32'd20;
		return $urandom;
	endfunction

	function automatic logic [4:0] bool_token();
		return $urandom_range(0, 1) ? FN_TRUE : FN_FALSE;
	endfunction

	// Holds valid and the payload until the transfer happens.
	task automatic send(input logic [4:0] f, input logic [31:0] v);
		int gap;
		gap = token_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tokens_sent++;
	endtask

	task automatic send_op(input logic [4:0] f);
		send(f, $urandom);
	endtask

	task automatic run_directed();
		send_op(FN_CLEAR);
		send_op(FN_DROP);
		send(FN_PUSH, 32'd7);
		send_op(FN_SWAP);
		send(FN_PUSH, 32'd1);
		send_op(FN_TRUE);
		send_op(FN_EQ);
		send_op(FN_NOT);
		send_op(FN_DUP);
		send_op(FN_SUB);
		send(FN_PUSH, INT_MAX);
		send(FN_PUSH, 32'd1);
		send_op(FN_ADD);
		send(FN_PUSH, 32'hffff_ffff);
		send_op(FN_DIV);
		send_op(FN_DUP);
		send_op(FN_MUL);
		send(FN_PUSH, -32'sd7);
		send(FN_PUSH, 32'd2);
		send_op(FN_MOD);
		send(FN_PUSH, 32'd0);
		send_op(FN_MOD);
		send_op(FN_FALSE);
		send_op(FN_LT);
		send_op(FN_PRINT);
		send(5'd31, INT_MIN);
		send(FN_PUSH, -32'sd5);
		send(FN_PUSH, 32'd3);
		send_op(FN_GT);
		send(FN_PUSH, 32'd4);
		send_op(FN_DUP);
		send_op(FN_LE);
		send(FN_PUSH, 32'd2);
		send(FN_PUSH, -32'sd2);
		send_op(FN_GE);
		send_op(FN_PRINT);
	endtask

	task automatic run_random(input int target);
		int kind;
		while (tokens_sent < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				send(FN_PUSH, rand_word());
				send(FN_PUSH, rand_word());
				send_op(5'($urandom_range(FN_ADD, FN_EQ)));
				if ($urandom_range(0, 1))
					send_op($urandom_range(0, 1) ? FN_DROP : FN_PRINT);
			end else if (kind < 55) begin
				send_op(bool_token());
				if ($urandom_range(0, 1))
					send(FN_PUSH, rand_word());
				else
					send_op(bool_token());
				case ($urandom_range(0, 2))
					0: send_op(FN_EQ);
					1: begin
						send_op(FN_NOT);
						send_op(FN_EQ);
					end
					default: send_op(5'($urandom_range(FN_ADD, FN_GE)));
				endcase
			end else if (kind < 70) begin
				send(FN_PUSH, rand_word());
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 4))
						0: send_op(FN_DUP);
						1: send_op(FN_SWAP);
						2: send_op(FN_DROP);
						3: send_op(FN_PRINT);
						default: send_op(FN_NOT);
					endcase
				end
			end else if (kind < 72) begin
				repeat (STACK_DEPTH + 2) begin
					case ($urandom_range(0, 3))
						0: send_op(FN_TRUE);
						1: send_op(FN_FALSE);
						2: send_op(FN_DUP);
						default: send(FN_PUSH, rand_word());
					endcase
				end
				if ($urandom_range(0, 1))
					send_op(FN_CLEAR);
			end else if (kind < 80) begin
				send_op(FN_CLEAR);
			end else begin
				repeat ($urandom_range(1, 3))
					send(5'($urandom_range(0, 31)), $urandom);
			end
		end
	endtask

	// Result side: short random stalls, ready runs, and a long hold-off every so
	// often that backs the block up while the sender keeps offering tokens.
	initial begin
		int cyc;
		int hold;
		int run;
		int r;
		cyc = 0;
		hold = 0;
		run = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (cyc % 2500 == 300) begin
				hold = $urandom_range(150, 300);
				out_ready <= 1'b0;
			end else if (run > 0) begin
				run--;
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 2)
					hold = $urandom_range(20, 60);
				else if (r < 15)
					hold = $urandom_range(1, 4);
				else if (r < 20)
					run = $urandom_range(20, 50);
				out_ready <= (hold == 0);
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(RANDOM_ITEMS);
		in_valid <= 1'b0;
		@(posedge clk);
		while (check_pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		@(negedge clk);
		if (check_errors == 0 && check_pending == 0)
			$display("rpn_stack_alu verification clean");
		else
			$display("rpn_stack_alu verification failed");
		$finish;
	end

endmodule

@@ rpn_stack_alu.f @@
rtl/rsa_pkg.sv
rtl/rsa_cell.sv
rtl/rsa_div.sv
rtl/rpn_stack_alu.sv
tb/rsa_token_checker.sv
tb/tb_top.sv
